// ===== hdl/mm_pkg.sv =====
// Shared sizes, codes, control types and command/status structs for the matrix multiplier.
package mm_pkg;

    localparam int MAX_DIM   = 64;
    localparam int DIM_W     = $clog2(MAX_DIM);
    localparam int CFG_W     = DIM_W + 1;
    localparam int ADDR_W    = 2 * DIM_W;
    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int DATA_W    = 16;
    localparam int MUL_W     = 2 * DATA_W;
    localparam int ACC_W     = 38;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 2;

    // operation codes of an input item
    localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_M  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_K = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_N  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_LOAD,
        ST_ERR
    } t_state;

    typedef struct packed {
        logic             wr_a;
        logic             wr_b;
        logic             rd;
        logic             first;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] lpos;
        logic [DIM_W-1:0] col;
        logic             load_out;
        logic             load_err;
        logic             last;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_sts;

endpackage

// ===== hdl/mm_ifs.sv =====
// Valid/ready channel interfaces: input items, result items and configuration writes.
interface mm_in_if import mm_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic [DIM_W-1:0]         row_index;
    logic [DIM_W-1:0]         col_index;
    logic signed [DATA_W-1:0] element_value;

    modport source (output valid, op, row_index, col_index, element_value, input ready);
    modport sink   (input valid, op, row_index, col_index, element_value, output ready);
    modport mon    (input valid, ready, op, row_index, col_index, element_value);
endinterface

interface mm_out_if import mm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [DIM_W-1:0]        result_column;
    logic signed [ACC_W-1:0] product_value;
    logic                    last;
    logic                    status;

    modport source (output valid, result_column, product_value, last, status, input ready);
    modport sink   (input valid, result_column, product_value, last, status, output ready);
endinterface

interface mm_cfg_if import mm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/matrix_multiply.sv =====
// Top level of the fixed-point matrix multiplier: controller plus datapath.
//
// Usage: load A (op write A) and B (op write B) one element per transfer on i_in,
// then request a result row (op compute). Each row request returns cols_n
// transfers on o_out in column order, each the exact 38-bit dot product with
// 24 fraction bits; last marks the final column. A row at or above rows_m gives
// one transfer with status 1, last 1, column 0 and value 0. Writes outside the
// configured sizes and op code 3 are dropped and produce nothing.
// Sizes rows_m, inner_k, cols_n are written on i_cfg (index 0, 1, 2) while idle, a rule
// for the user that the block does not enforce; 0 acts as 1 and values above 64 act
// as 64. i_cfg is always ready. Writes on i_in are taken back to back while idle.
// Each column is worked by one shared multiply-accumulate fed from one read port per
// memory: inner_k term reads, then a drain of the read and multiply registers, then
// a load of the output register.
// Stall: i_in is ready only while idle. A column holds in its load step until the
// output register frees; after the final column the block is idle and takes transfers.
// Reset (synchronous, active low) returns to idle with sizes at 64 and the
// output empty. Element memories are not cleared; read only what was written.
module matrix_multiply import mm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    mm_in_if.sink    i_in,
    mm_out_if.source o_out,
    mm_cfg_if.sink   i_cfg
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer: decodes transfers, holds sizes, steps row/column/term
    mm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // memories, multiply-accumulate and output register
    mm_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

endmodule

// ===== hdl/mm_ctrl.sv =====
// Controller: size registers, item decode and the row/column/term sequencer.
module mm_ctrl import mm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    mm_in_if.sink   i_in,
    mm_cfg_if.sink  i_cfg,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state           r_state, n_state;
    logic [CFG_W-1:0] r_rows_m, r_inner_k, r_cols_n;
    logic [DIM_W-1:0] r_row, n_row;
    logic [DIM_W-1:0] r_lpos, n_lpos;
    logic [DIM_W-1:0] r_col, n_col;
    logic             r_drain, n_drain;
    logic             accept;
    logic             last_l;
    logic             last_col;
    logic [CFG_W-1:0] cfg_val;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign accept      = i_in.valid && i_in.ready;
    assign last_l      = ({1'b0, r_lpos} + CFG_W'(1)) == r_inner_k;
    assign last_col    = ({1'b0, r_col} + CFG_W'(1)) == r_cols_n;

    // clamp written size into 1..MAX_DIM
    always_comb begin
        if (i_cfg.data == '0) begin
            cfg_val = CFG_W'(1);
        end else if (i_cfg.data > CFG_W'(MAX_DIM)) begin
            cfg_val = CFG_W'(MAX_DIM);
        end else begin
            cfg_val = i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_m  <= CFG_W'(MAX_DIM);
            r_inner_k <= CFG_W'(MAX_DIM);
            r_cols_n  <= CFG_W'(MAX_DIM);
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_ROWS_M:  r_rows_m  <= cfg_val;
                REG_INNER_K: r_inner_k <= cfg_val;
                REG_COLS_N:  r_cols_n  <= cfg_val;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= '0;
            r_lpos  <= '0;
            r_col   <= '0;
            r_drain <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_lpos  <= n_lpos;
            r_col   <= n_col;
            r_drain <= n_drain;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_row      = r_row;
        n_lpos     = r_lpos;
        n_col      = r_col;
        n_drain    = r_drain;

        o_cmd          = '0;
        o_cmd.row      = r_row;
        o_cmd.lpos     = r_lpos;
        o_cmd.col      = r_col;
        o_cmd.first    = (r_lpos == '0);
        o_cmd.last     = last_col;

        o_cmd.wr_a = accept && (i_in.op == OP_WRITE_A)
                     && ({1'b0, i_in.row_index} < r_rows_m)
                     && ({1'b0, i_in.col_index} < r_inner_k);
        o_cmd.wr_b = accept && (i_in.op == OP_WRITE_B)
                     && ({1'b0, i_in.row_index} < r_inner_k)
                     && ({1'b0, i_in.col_index} < r_cols_n);

        case (r_state)
            ST_IDLE: begin
                if (accept && (i_in.op == OP_COMPUTE)) begin
                    n_row  = i_in.row_index;
                    n_lpos = '0;
                    n_col  = '0;
                    if ({1'b0, i_in.row_index} < r_rows_m) begin
                        n_state = ST_RUN;
                    end else begin
                        n_state = ST_ERR;
                    end
                end
            end
            ST_RUN: begin
                o_cmd.rd = 1'b1;
                if (last_l) begin
                    n_drain = 1'b0;
                    n_state = ST_DRAIN;
                end else begin
                    n_lpos = r_lpos + DIM_W'(1);
                end
            end
            ST_DRAIN: begin
                n_drain = 1'b1;
                if (r_drain) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_lpos         = '0;
                    if (last_col) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_col   = r_col + DIM_W'(1);
                        n_state = ST_RUN;
                    end
                end
            end
            ST_ERR: begin
                if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.load_err = 1'b1;
                    o_cmd.last     = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> !i_sts.out_busy)
        else $error("result loaded while output register still held");

    a_sizes_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rows_m != '0 && r_inner_k != '0 && r_cols_n != '0
        && r_rows_m <= CFG_W'(MAX_DIM) && r_inner_k <= CFG_W'(MAX_DIM)
        && r_cols_n <= CFG_W'(MAX_DIM))
        else $error("size register outside 1..MAX_DIM");

    a_next_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD && !i_sts.out_busy && !last_col)
        |=> (r_state == ST_RUN && r_lpos == '0))
        else $error("next column did not restart at term zero");

    a_run_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> ({1'b0, r_lpos} < r_inner_k && {1'b0, r_col} < r_cols_n))
        else $error("sequencer index beyond configured size");

endmodule

// ===== hdl/mm_dpath.sv =====
// Datapath: A and B element memories, multiply-accumulate pipeline and output register.
module mm_dpath import mm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    mm_in_if.sink   i_in,
    mm_out_if.source o_out,
    input  t_dp_cmd i_cmd,
    output t_dp_sts o_sts
);

    logic signed [DATA_W-1:0] a_mem [DEPTH];
    logic signed [DATA_W-1:0] b_mem [DEPTH];

    logic [ADDR_W-1:0]        wr_addr;
    logic [ADDR_W-1:0]        a_rd_addr;
    logic [ADDR_W-1:0]        b_rd_addr;

    logic signed [DATA_W-1:0] r_a_q, r_b_q;
    logic                     r_rd_v, r_rd_first;
    logic signed [MUL_W-1:0]  r_prod;
    logic                     r_mul_v, r_mul_first;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  prod_ext;

    logic                     r_out_valid;
    logic [DIM_W-1:0]         r_out_col;
    logic signed [ACC_W-1:0]  r_out_val;
    logic                     r_out_last;
    logic                     r_out_status;

    assign wr_addr   = {i_in.row_index, i_in.col_index};
    assign a_rd_addr = {i_cmd.row, i_cmd.lpos};
    assign b_rd_addr = {i_cmd.lpos, i_cmd.col};
    assign prod_ext  = ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a) begin
            a_mem[wr_addr] <= i_in.element_value;
        end
        if (i_cmd.rd) begin
            r_a_q <= a_mem[a_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_b) begin
            b_mem[wr_addr] <= i_in.element_value;
        end
        if (i_cmd.rd) begin
            r_b_q <= b_mem[b_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v  <= 1'b0;
            r_mul_v <= 1'b0;
        end else begin
            r_rd_v  <= i_cmd.rd;
            r_mul_v <= r_rd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_first  <= i_cmd.first;
        r_mul_first <= r_rd_first;
        r_prod      <= r_a_q * r_b_q;
        if (r_mul_v) begin
            r_acc <= r_mul_first ? prod_ext : r_acc + prod_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_col    <= i_cmd.load_err ? '0 : i_cmd.col;
            r_out_val    <= i_cmd.load_err ? '0 : r_acc;
            r_out_last   <= i_cmd.last;
            r_out_status <= i_cmd.load_err;
        end
    end

    assign o_sts.out_busy      = r_out_valid && !o_out.ready;
    assign o_out.valid         = r_out_valid;
    assign o_out.result_column = r_out_col;
    assign o_out.product_value = r_out_val;
    assign o_out.last          = r_out_last;
    assign o_out.status        = r_out_status;

endmodule

// ===== verif/mm_product_checker.sv =====
// Checker for the matrix multiplier: predicts every result row and compares each output transfer.
module mm_product_checker import mm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    mm_in_if.mon i_in_mon,
    mm_out_if    i_out_mon,
    mm_cfg_if    i_cfg_mon,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct {
        logic [DIM_W-1:0]        col;
        logic signed [ACC_W-1:0] value;
        logic                    last;
        logic                    status;
    } t_row_result;

    t_row_result              row_results_q[$];
    logic signed [DATA_W-1:0] a_elem [DEPTH];
    logic signed [DATA_W-1:0] b_elem [DEPTH];
    int                       rows_eff;
    int                       inner_eff;
    int                       cols_eff;
    int                       mismatch_cnt = 0;

    assign o_fail_count = mismatch_cnt;

    // 0 acts as 1, anything above the largest size acts as the largest size
    function automatic int clamp_size(input logic [CFG_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > MAX_DIM)
            return MAX_DIM;
        return int'(raw);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_cnt++;
    endtask

    // Queue the whole row of C, or a single error entry for a row past rows_m.
    function automatic void queue_row_products(input int row);
        t_row_result res;
        longint      sum;
        if (row >= rows_eff) begin
            res.col    = '0;
            res.value  = '0;
            res.last   = 1'b1;
            res.status = 1'b1;
            row_results_q.push_back(res);
            return;
        end
        for (int j = 0; j < cols_eff; j++) begin
            sum = 0;
            for (int l = 0; l < inner_eff; l++)
                sum += longint'(a_elem[row * MAX_DIM + l]) * longint'(b_elem[l * MAX_DIM + j]);
            res.col    = DIM_W'(j);
            res.value  = ACC_W'(sum);
            res.last   = (j == cols_eff - 1);
            res.status = 1'b0;
            row_results_q.push_back(res);
        end
    endfunction

    always @(posedge i_clk) begin
        t_row_result want;
        int          row;
        int          col;
        if (!i_rst_n) begin
            row_results_q.delete();
            rows_eff  = MAX_DIM;
            inner_eff = MAX_DIM;
            cols_eff  = MAX_DIM;
        end else begin
            if (i_cfg_mon.valid && i_cfg_mon.ready) begin
                case (i_cfg_mon.index)
                    REG_ROWS_M:  rows_eff  = clamp_size(i_cfg_mon.data);
                    REG_INNER_K: inner_eff = clamp_size(i_cfg_mon.data);
                    REG_COLS_N:  cols_eff  = clamp_size(i_cfg_mon.data);
                    default: ;
                endcase
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (row_results_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result col %0d value %0d last %b status %b",
                        i_out_mon.result_column, i_out_mon.product_value,
                        i_out_mon.last, i_out_mon.status));
                end else begin
                    want = row_results_q.pop_front();
                    if (i_out_mon.result_column !== want.col)
                        report_mismatch($sformatf("result_column %0d, want %0d",
                            i_out_mon.result_column, want.col));
                    if (i_out_mon.product_value !== want.value)
                        report_mismatch($sformatf("product_value %0d, want %0d (col %0d)",
                            i_out_mon.product_value, want.value, want.col));
                    if (i_out_mon.last !== want.last)
                        report_mismatch($sformatf("last %b, want %b (col %0d)",
                            i_out_mon.last, want.last, want.col));
                    if (i_out_mon.status !== want.status)
                        report_mismatch($sformatf("status %b, want %b (col %0d)",
                            i_out_mon.status, want.status, want.col));
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                row = int'(i_in_mon.row_index);
                col = int'(i_in_mon.col_index);
                case (i_in_mon.op)
                    OP_WRITE_A:
                        if (row < rows_eff && col < inner_eff)
                            a_elem[row * MAX_DIM + col] = i_in_mon.element_value;
                    OP_WRITE_B:
                        if (row < inner_eff && col < cols_eff)
                            b_elem[row * MAX_DIM + col] = i_in_mon.element_value;
                    OP_COMPUTE:
                        queue_row_products(row);
                    default: ;
                endcase
            end
        end
        o_pending <= row_results_q.size();
    end

endmodule

// ===== verif/testbench.sv =====
// Top of the matrix multiplier testbench: clock, reset, stimulus, output backpressure and verdict.
module testbench;
    import mm_pkg::*;

    // codes the package leaves unnamed; the block must drop both
    localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam logic signed [DATA_W-1:0] ELEM_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] ELEM_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    localparam int ITEM_TARGET   = 130;
    localparam int HOLD_CYCLES   = 300;
    // give the pipe room to empty
    localparam int SETTLE_CYCLES = 80;
    // limit for the whole run, far above the slowest sane run
    localparam int CYCLE_LIMIT   = 1_000_000;

    logic i_clk;
    logic i_rst_n;
    int   fail_cnt;
    int   pending_cnt;
    int   cycle_cnt     = 0;
    int   snd_idle_pct  = 0;
    int   rcv_stall_pct = 0;
    logic holding;
    event hold_ev;

    // sizes the block is currently running with, after clamping
    int cur_m = MAX_DIM;
    int cur_k = MAX_DIM;
    int cur_n = MAX_DIM;
    // every input transfer, loads and requests alike
    int item_cnt = 0;

    // which store entries have been written; a row request never reads a hole
    bit a_loaded [MAX_DIM][MAX_DIM];
    bit b_loaded [MAX_DIM][MAX_DIM];

    mm_in_if  in_ch ();
    mm_out_if out_ch ();
    mm_cfg_if cfg_ch ();

    matrix_multiply dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    mm_product_checker prod_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .i_cfg_mon    (cfg_ch),
        .o_fail_count (fail_cnt),
        .o_pending    (pending_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: count cycles and give up once the limit is reached.
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("status: fail");
        $finish;
    end

    // Long receiver hold-off: drop ready for a fixed stretch whenever triggered.
    initial begin
        holding <= 1'b0;
        forever begin
            @(hold_ev);
            holding <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            holding <= 1'b0;
        end
    end

    // Result receiver: stall at the current rate, and hold fully during a hold-off.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= !holding && ($urandom_range(0, 99) >= rcv_stall_pct);
        end
    end

    // Mostly random elements, with the two extremes showing up often.
    function automatic logic signed [DATA_W-1:0] rand_elem();
        case ($urandom_range(0, 7))
            0:       return ELEM_MIN;
            1:       return ELEM_MAX;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    function automatic int effective_size(input int raw);
        if (raw == 0)
            return 1;
        if (raw > MAX_DIM)
            return MAX_DIM;
        return raw;
    endfunction

    // Raw size for a phase: mostly small, sometimes 0. Only a row count may go past
    // the top, since a large row count costs no extra loads.
    function automatic int pick_size_raw(input bit allow_big);
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return 0;
        if (pick == 1 && allow_big)
            return $urandom_range(MAX_DIM + 1, 127);
        return $urandom_range(1, 4);
    endfunction

    // Offer one item, idling first at the sender rate, and hold it until the transfer.
    task automatic put_item(input logic [OP_W-1:0] op, input int row, input int col,
                            input logic signed [DATA_W-1:0] val);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.op            <= op;
        in_ch.row_index     <= DIM_W'(row);
        in_ch.col_index     <= DIM_W'(col);
        in_ch.element_value <= val;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        item_cnt++;
        // writes outside the current sizes are dropped by the block, so leave them unmarked
        if (op == OP_WRITE_A && row < cur_m && col < cur_k)
            a_loaded[row][col] = 1'b1;
        if (op == OP_WRITE_B && row < cur_k && col < cur_n)
            b_loaded[row][col] = 1'b1;
    endtask

    // Write whatever a request for this row would read that is still missing.
    task automatic fill_row_operands(input int row);
        for (int l = 0; l < cur_k; l++)
            if (!a_loaded[row][l])
                put_item(OP_WRITE_A, row, l, rand_elem());
        for (int l = 0; l < cur_k; l++)
            for (int j = 0; j < cur_n; j++)
                if (!b_loaded[l][j])
                    put_item(OP_WRITE_B, l, j, rand_elem());
    endtask

    // Request one result row; col and element fields are don't-care, so randomize them.
    task automatic request_row(input int row);
        if (row < cur_m)
            fill_row_operands(row);
        put_item(OP_COMPUTE, row, $urandom_range(0, MAX_DIM - 1), rand_elem());
    endtask

    // Drop valid and wait until every predicted result has come out, then let the pipe drain.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int raw);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= CFG_W'(raw);
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Reconfigure only once the block is idle; sometimes poke the unused index as well.
    task automatic set_sizes(input int rm, input int rk, input int rn);
        wait_idle();
        cfg_write(REG_ROWS_M, rm);
        cur_m = effective_size(rm);
        cfg_write(REG_INNER_K, rk);
        cur_k = effective_size(rk);
        cfg_write(REG_COLS_N, rn);
        cur_n = effective_size(rn);
        if ($urandom_range(0, 3) == 0)
            cfg_write(REG_UNUSED, $urandom_range(0, 127));
    endtask

    // One random item: mostly in-range loads and row requests, plus dropped noise.
    task automatic random_item();
        int pick;
        int row;
        int col;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            row = ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_DIM - 1)
                                              : $urandom_range(0, cur_m - 1);
            request_row(row);
        end else if (pick < 60) begin
            row = ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_DIM - 1)
                                              : $urandom_range(0, cur_m - 1);
            col = ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_DIM - 1)
                                              : $urandom_range(0, cur_k - 1);
            put_item(OP_WRITE_A, row, col, rand_elem());
        end else if (pick < 85) begin
            row = ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_DIM - 1)
                                              : $urandom_range(0, cur_k - 1);
            col = ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_DIM - 1)
                                              : $urandom_range(0, cur_n - 1);
            put_item(OP_WRITE_B, row, col, rand_elem());
        end else begin
            put_item(OP_UNUSED, $urandom_range(0, MAX_DIM - 1), $urandom_range(0, MAX_DIM - 1),
                     rand_elem());
        end
    endtask

    // Hold the receiver off while requests keep coming, so the block fills and stalls input.
    task automatic apply_backpressure();
        int row;
        row = $urandom_range(0, cur_m - 1);
        fill_row_operands(row);
        -> hold_ev;
        repeat (6)
            request_row(row);
    endtask

    initial begin
        int phase_no;
        in_ch.valid         <= 1'b0;
        in_ch.op            <= OP_WRITE_A;
        in_ch.row_index     <= '0;
        in_ch.col_index     <= '0;
        in_ch.element_value <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= REG_ROWS_M;
        cfg_ch.data         <= '0;
        i_rst_n             <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Signed extremes: row 0 of A all at the negative extreme, column 0 of B at the
        // negative extreme and column 1 at the positive one, so the sums pass 32 bits
        // both ways.
        set_sizes(4, 4, 2);
        for (int l = 0; l < 4; l++) begin
            put_item(OP_WRITE_A, 0, l, ELEM_MIN);
            put_item(OP_WRITE_B, l, 0, ELEM_MIN);
            put_item(OP_WRITE_B, l, 1, ELEM_MAX);
        end
        request_row(0);
        // a row count past the top acts as full size, so the last row stays in range
        set_sizes(MAX_DIM + 1, 1, 1);
        request_row(MAX_DIM - 1);

        // Directed corners: zero sizes act as one, dropped writes, unused op, bad rows.
        set_sizes(0, 0, 0);
        put_item(OP_WRITE_A, 0, 0, ELEM_MIN);
        put_item(OP_WRITE_B, 0, 0, ELEM_MIN);
        request_row(0);
        put_item(OP_WRITE_A, 1, 0, ELEM_MAX);   // row past rows_m
        put_item(OP_WRITE_A, 0, 1, ELEM_MAX);   // column past inner_k
        put_item(OP_WRITE_B, 1, 0, ELEM_MAX);   // row past inner_k
        put_item(OP_WRITE_B, 0, 1, ELEM_MAX);   // column past cols_n
        request_row(0);                         // must be unchanged by the dropped writes
        put_item(OP_UNUSED, MAX_DIM - 1, MAX_DIM - 1, ELEM_MAX);
        request_row(1);
        request_row(MAX_DIM - 1);
        // other sizes read the older elements where they were left
        set_sizes(3, 2, 4);
        put_item(OP_WRITE_A, 2, 0, ELEM_MAX);
        put_item(OP_WRITE_A, 2, 1, ELEM_MIN);
        request_row(2);
        request_row(3);
        request_row(0);

        // Random phases, rotating through the idle patterns: none, sender idle,
        // receiver stalling, both. The first receiver-stall phase adds a long hold-off.
        phase_no = 0;
        while (phase_no < 4 || item_cnt < ITEM_TARGET) begin
            set_sizes(pick_size_raw(1'b1), pick_size_raw(1'b0), pick_size_raw(1'b0));
            case (phase_no % 4)
                0: begin
                    snd_idle_pct  = 0;
                    rcv_stall_pct <= 0;
                end
                1: begin
                    snd_idle_pct  = 54;
                    rcv_stall_pct <= 0;
                end
                2: begin
                    snd_idle_pct  = 0;
                    rcv_stall_pct <= 54;
                end
                default: begin
                    snd_idle_pct  = 15;
                    rcv_stall_pct <= 15;
                end
            endcase
            if (phase_no == 2)
                apply_backpressure();
            repeat ($urandom_range(6, 10)) random_item();
            phase_no++;
        end

        wait_idle();
        if (fail_cnt == 0 && pending_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
